>>> src/bmorph_pkg.sv
`default_nettype none

package bmorph_pkg;

    // Configuration register widths and the widest of them
    localparam int MODE_W     = 1;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam int IMG_W_RST = 640;
    localparam int IMG_H_RST = 480;

    // Pixel width and the foreground and background result values
    localparam int                PIX_W  = 8;
    localparam logic [PIX_W-1:0]  PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_BG = 8'd0;

    // Input actions
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Operating modes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    // 3x3 window masks: bit = column * 3 + row, column 0 left, row 0 up
    localparam logic [8:0] WIN_LEFT  = 9'h007;
    localparam logic [8:0] WIN_RIGHT = 9'h1C0;
    localparam logic [8:0] WIN_UP    = 9'h049;
    localparam logic [8:0] WIN_DOWN  = 9'h124;

endpackage

`default_nettype wire

>>> src/bmorph_ram.sv
`default_nettype none

module bmorph_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/binary_morphology_3x3.sv
`default_nettype none

// Streaming 3x3 binary erosion / dilation. Pixels of one frame enter in raster
// order, one transaction per cycle; any nonzero pixel is foreground and each
// result is 0 or 255. Neighbours outside the frame are ignored. Results lag
// the input by one row plus one pixel, so after the last pixel the frame needs
// image_width + 1 flush transactions (or further pushes, which act as flushes)
// to drain; frame_last marks the final result and the next push starts a new
// frame. The result a transaction completes passes through stage 1 to the
// output register: the registered read of the line store (one 2-bit word per
// column holding the two rows above) is issued as the transaction is taken,
// and the window update and result follow when stage 1 retires. Sustained
// rate is one pixel per cycle, set by the single read and single write of the
// line store per pixel; it drops only while a finished result waits at the
// output. A flush taken before the frame is complete is discarded. Register
// writes restart the frame; the user must make them only while idle (not enforced).
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [bmorph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bmorph_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel input
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [bmorph_pkg::PIX_W-1:0]        pixel,
    // result output
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [bmorph_pkg::PIX_W-1:0]        out_pixel,
    output logic      [$clog2(MAX_HEIGHT)-1:0]       out_row,
    output logic      [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic                                     frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int RO = $clog2(MAX_HEIGHT);       // result row index
    localparam int RW = $clog2(MAX_HEIGHT + 2);   // input row, runs to height + 1
    localparam int WW = $clog2(MAX_WIDTH + 1);    // clamped width
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // clamped height

    function automatic logic [WW-1:0] clamp_w(input logic [31:0] v);
        logic [31:0] r;
        begin
            r = v;
            if (v == 32'd0)
            begin
                r = 32'd1;
            end
            else if (v > 32'(MAX_WIDTH))
            begin
                r = 32'(MAX_WIDTH);
            end
            return r[WW-1:0];
        end
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [31:0] v);
        logic [31:0] r;
        begin
            r = v;
            if (v == 32'd0)
            begin
                r = 32'd1;
            end
            else if (v > 32'(MAX_HEIGHT))
            begin
                r = 32'(MAX_HEIGHT);
            end
            return r[HW-1:0];
        end
    endfunction

    localparam logic [WW-1:0] W_RST = clamp_w(32'(bmorph_pkg::IMG_W_RST));
    localparam logic [HW-1:0] H_RST = clamp_h(32'(bmorph_pkg::IMG_H_RST));

    // Configuration, held clamped
    logic          mode_reg;
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic          restart;

    // Input side counters
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;

    // Stage 1: line store data returning
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_v_reg;
    logic [CW-1:0] s1_c_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic          s1_c0_reg;
    logic          fwd_reg, fwd_next;
    logic [1:0]    fwd_data_reg;

    // Window and result position
    logic [8:0]    window_reg, window_next;
    logic [CW-1:0] res_col_reg, res_col_next;
    logic [RO-1:0] res_row_reg, res_row_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [bmorph_pkg::PIX_W-1:0] out_pixel_reg;
    logic [RO-1:0] out_row_reg;
    logic [CW-1:0] out_col_reg;
    logic          out_last_reg;

    // Derived limits
    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;
    logic [RW-1:0] h_ext;
    logic [RW-1:0] h_p1;

    assign w_m1  = w_reg - 1'b1;
    assign h_m1  = h_reg - 1'b1;
    assign h_ext = RW'(h_reg);
    assign h_p1  = h_ext + 1'b1;

    // Stage 0 decode
    logic       accept;
    logic       in_frame;
    logic       work;
    logic       v0;
    logic       emit0;
    logic       last0;
    logic       col_end0;
    logic       s1_go;

    assign accept   = in_valid && in_ready;
    assign in_frame = (in_row_reg < h_ext);
    assign work     = accept && (!in_frame || (action == bmorph_pkg::ACT_PUSH));
    assign v0       = in_frame && (pixel != '0);
    assign emit0    = (in_row_reg >= RW'(2))
                   || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign last0    = (in_row_reg == h_p1) && (in_col_reg == '0);
    assign col_end0 = (WW'(in_col_reg) == w_m1);

    // Stage 1 may retire unless its result has no room
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    // Line store: bit 0 upper row, bit 1 middle row
    logic [1:0] ram_rdata;
    logic [1:0] line_bits;
    logic [1:0] wb_data;

    assign line_bits = fwd_reg ? fwd_data_reg : ram_rdata;
    assign wb_data   = {s1_v_reg, line_bits[1]};

    bmorph_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_c_reg),
        .wdata (wb_data),
        .re    (work),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // Window update and result
    logic [8:0] win_shift;
    logic [8:0] e_bits;
    logic [8:0] mask;
    logic       hit;
    logic       res_col_end;

    assign win_shift   = {s1_v_reg, line_bits, window_reg[8:3]};
    assign e_bits      = s1_c0_reg ? {3'b000, window_reg[8:3]} : win_shift;
    assign res_col_end = (WW'(res_col_reg) == w_m1);

    always_comb
    begin
        mask = 9'h1FF;
        if (res_col_reg == '0)
        begin
            mask = mask & ~bmorph_pkg::WIN_LEFT;
        end
        if (res_col_end)
        begin
            mask = mask & ~bmorph_pkg::WIN_RIGHT;
        end
        if (res_row_reg == '0)
        begin
            mask = mask & ~bmorph_pkg::WIN_UP;
        end
        if (HW'(res_row_reg) == h_m1)
        begin
            mask = mask & ~bmorph_pkg::WIN_DOWN;
        end
        unique case (mode_reg)
            bmorph_pkg::MODE_ERODE:  hit = ((e_bits & mask) == mask);
            bmorph_pkg::MODE_DILATE: hit = ((e_bits & mask) != '0);
            default:                 hit = 1'b0;
        endcase
    end

    // Next-state logic
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        s1_valid_next  = s1_valid_reg;
        fwd_next       = fwd_reg;
        window_next    = window_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // input counters advance on each working transaction
        if (work)
        begin
            if (last0)
            begin
                in_col_next = '0;
                in_row_next = '0;
            end
            else if (col_end0)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        if (accept)
        begin
            s1_valid_next = work;
            fwd_next      = s1_go && (s1_c_reg == in_col_reg);
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        // retire stage 1
        if (s1_go)
        begin
            window_next = s1_last_reg ? '0 : win_shift;
            if (s1_emit_reg)
            begin
                out_valid_next = 1'b1;
                if (s1_last_reg)
                begin
                    res_col_next = '0;
                    res_row_next = '0;
                end
                else if (res_col_end)
                begin
                    res_col_next = '0;
                    res_row_next = res_row_reg + 1'b1;
                end
                else
                begin
                    res_col_next = res_col_reg + 1'b1;
                end
            end
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            window_next  = '0;
            res_col_next = '0;
            res_row_next = '0;
        end
    end

    // Register write decode
    always_comb
    begin
        unique case (cfg_index)
            bmorph_pkg::CFG_MODE,
            bmorph_pkg::CFG_WIDTH,
            bmorph_pkg::CFG_HEIGHT: restart = cfg_we;
            default:                restart = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= bmorph_pkg::MODE_ERODE;
            w_reg         <= W_RST;
            h_reg         <= H_RST;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            window_reg    <= '0;
            res_col_reg   <= '0;
            res_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bmorph_pkg::CFG_MODE:   mode_reg <= cfg_data[0];
                    bmorph_pkg::CFG_WIDTH:
                        w_reg <= clamp_w(32'(cfg_data[bmorph_pkg::IMG_W_W-1:0]));
                    bmorph_pkg::CFG_HEIGHT:
                        h_reg <= clamp_h(32'(cfg_data[bmorph_pkg::IMG_H_W-1:0]));
                    default: ;
                endcase
            end
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            window_reg    <= window_next;
            res_col_reg   <= res_col_next;
            res_row_reg   <= res_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (work)
        begin
            s1_v_reg     <= v0;
            s1_c_reg     <= in_col_reg;
            s1_emit_reg  <= emit0;
            s1_last_reg  <= last0;
            s1_c0_reg    <= (in_col_reg == '0);
            fwd_data_reg <= wb_data;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_pixel_reg <= hit ? bmorph_pkg::PIX_FG : bmorph_pkg::PIX_BG;
            out_row_reg   <= res_row_reg;
            out_col_reg   <= res_col_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = out_last_reg;

    // Checks
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg)
            |-> ((WW'(out_col_reg) == w_m1) && (HW'(out_row_reg) == h_m1)))
        else $error("frame_last away from the bottom right pixel");

    // same column twice in a row: one-pixel frame, or a new frame after the last
    a_fwd_width: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_reg) |-> ((w_reg == WW'(1)) || (s1_c_reg == '0)))
        else $error("line store forward away from a repeated column");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(in_col_reg) < w_reg)
        else $error("input column beyond frame width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= h_p1)
        else $error("input row beyond drain row");

    a_win_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (window_reg == '0))
        else $error("window not cleared after frame end");

endmodule

`default_nettype wire
